>>> rtl/f2r_pkg.sv
`timescale 1ns / 1ps
package f2r_pkg;

  // Largest signed 64-bit value and the binary64 patterns of the range limits.
  localparam logic [63:0] LMAX       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TWO63_BITS = 64'h43E0_0000_0000_0000;
  localparam logic [63:0] LO_BITS    = 64'h3C00_0000_0000_0000;

  localparam logic [10:0] EXP_INF    = 11'h7FF;
  localparam logic [10:0] EXP_ONE    = 11'd1023;
  localparam logic [10:0] EXP_UNIT   = 11'd1075;
  localparam logic [10:0] EXP_MAXINT = 11'd1085;

  localparam logic [52:0] ONE_MANT   = 53'h10_0000_0000_0000;

  typedef logic signed [13:0] exp_t;

  // Biased exponent of a value whose leading one sits at bit 127 of the rounder word.
  localparam exp_t NORM_BIAS = 14'sd1150;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONFINITE = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef struct packed {
    logic [127:0] w;
    exp_t         ew;
    logic         sticky;
  } norm_req_t;

endpackage

>>> rtl/f2r_mul.sv
`timescale 1ns / 1ps
module f2r_mul
  import f2r_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic         busy_r;
  logic         done_r;
  logic [1:0]   cnt_r;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [127:0] acc_r;
  logic [79:0]  part;

  // One 16-bit digit of b per cycle, most significant digit first.
  assign part = {16'b0, a_r} * {64'b0, b_r[63:48]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        cnt_r  <= 2'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= (acc_r << 16) + {48'b0, part};
        b_r   <= b_r << 16;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> rtl/f2r_div.sv
`timescale 1ns / 1ps
module f2r_div
  import f2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [52:0] mn,
  input  logic [52:0] md,
  output logic        done,
  output logic [56:0] q,
  output logic        sticky
);

  localparam int unsigned STEPS = 57;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [53:0] rem_r;
  logic [52:0] md_r;
  logic [56:0] q_r;
  logic        ge;
  logic [53:0] diff;

  // Restoring division, one quotient bit per cycle; the remainder stays below 2*md.
  assign ge   = rem_r >= {1'b0, md_r};
  assign diff = ge ? (rem_r - {1'b0, md_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        rem_r  <= {1'b0, mn};
        md_r   <= md;
        q_r    <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= {diff[52:0], 1'b0};
        q_r   <= {q_r[55:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign q      = q_r;
  assign sticky = rem_r != '0;

endmodule

>>> rtl/f2r_norm.sv
`timescale 1ns / 1ps
module f2r_norm
  import f2r_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  norm_req_t req,
  output logic      done,
  output logic [63:0] res
);

  logic         busy_r;
  logic         done_r;
  logic [127:0] w_r;
  exp_t         ew_r;
  logic         st_r;
  logic [63:0]  res_r;
  exp_t         expb;
  logic         up;

  // Round to nearest even on the 52 fraction bits below the leading one; a carry out of
  // the fraction runs into the exponent field of the pattern.
  assign expb = ew_r + NORM_BIAS;
  assign up   = w_r[74] & ((|w_r[73:0]) | st_r | w_r[75]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        w_r    <= req.w;
        ew_r   <= req.ew;
        st_r   <= req.sticky;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        priority if (w_r == '0) begin
          res_r  <= '0;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else if (w_r[127:96] == '0) begin
          w_r  <= w_r << 32;
          ew_r <= ew_r - 14'sd32;
        end else if (w_r[127:120] == '0) begin
          w_r  <= w_r << 8;
          ew_r <= ew_r - 14'sd8;
        end else if (!w_r[127]) begin
          w_r  <= w_r << 1;
          ew_r <= ew_r - 14'sd1;
        end else begin
          res_r  <= {1'b0, expb[10:0], w_r[126:75]} + {63'b0, up};
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

>>> rtl/float_to_rational_cont_frac.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                                          Beat taken when
// input     in         start, busy, in_value_bits                     start && !busy
// result    out        out_valid, out_status, out_numerator,          out_valid (one cycle)
//                      out_denominator
//
// A beat that is a special case (non-finite, whole number, out of range or an
// exact range limit) is settled in the check state, and its result is registered
// from there. Every continued-fraction step runs two multiplies, two passes of
// the restoring divider and six passes of the normalize-and-round unit, with one
// divide and one rounding fewer when the new numerator is zero. Reset is
// synchronous and active low and clears only the sequencer and strobes. The
// receiver cannot stall the result.
module float_to_rational_cont_frac
  import f2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value_bits,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic signed [63:0] out_numerator,
  output logic [62:0] out_denominator
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_HB_CVT, S_LOOP, S_MUL_H, S_MUL_K, S_CVT_H, S_CVT_K,
    S_DIV_Q, S_RND_Q, S_SUB, S_SUB_W, S_REM, S_DIV_X, S_RND_X
  } state_t;

  // Integer part, fraction bits and half bit of a binary64 magnitude.
  typedef struct packed {
    logic [63:0] ip;
    logic [52:0] fr;
    logic        half;
  } split_t;

  function automatic split_t split(input logic [52:0] m, input logic [10:0] e);
    split_t     s;
    logic [10:0] sh;
    s  = '0;
    sh = '0;
    if (e >= EXP_UNIT) begin
      s.ip = {11'b0, m} << (e - EXP_UNIT);
    end else begin
      sh     = EXP_UNIT - e;
      s.ip   = (sh > 11'd63) ? 64'd0 : ({11'b0, m} >> sh[5:0]);
      s.fr   = (sh > 11'd52) ? m : (m & ~({53{1'b1}} << sh[5:0]));
      s.half = (sh > 11'd53) ? 1'b0 : m[6'(sh[5:0] - 6'd1)];
    end
    return s;
  endfunction

  state_t      state_r;
  logic        busy_r;
  logic        out_valid_r;
  status_t     out_status_r;
  logic [63:0] out_num_r;
  logic [62:0] out_den_r;

  logic        neg_r;
  logic        init_r;
  logic [63:0] mag_r, x_r, q_r, dh_r, min_err_r;
  logic [63:0] a_r, hb_r, kb_r, h0_r, h1_r, k0_r, k1_r, hn_r, kn_r;
  logic [52:0] frac_r;
  exp_t        frew_r;
  logic [10:0] en_r, ed_r;

  logic        mul_go_r, div_go_r, norm_go_r;
  logic [63:0] mul_b_r;
  logic [52:0] div_mn_r, div_md_r;
  norm_req_t   norm_req_r;

  logic         mul_done, div_done, norm_done, div_sticky;
  logic [127:0] mul_prod;
  logic [56:0]  div_q;
  logic [63:0]  norm_res;

  f2r_mul u_mul (
    .clk(clk), .rst_n(rst_n), .go(mul_go_r), .a(a_r), .b(mul_b_r),
    .done(mul_done), .prod(mul_prod)
  );

  f2r_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go_r), .mn(div_mn_r), .md(div_md_r),
    .done(div_done), .q(div_q), .sticky(div_sticky)
  );

  f2r_norm u_norm (
    .clk(clk), .rst_n(rst_n), .go(norm_go_r), .req(norm_req_r),
    .done(norm_done), .res(norm_res)
  );

  // Decode of the latched input magnitude.
  logic [10:0] in_e;
  logic [52:0] in_m;
  split_t      in_sp;
  logic [63:0] hb_start;

  assign in_e     = mag_r[62:52];
  assign in_m     = {in_e != 11'd0, mag_r[51:0]};
  assign in_sp    = split(in_m, in_e);
  assign hb_start = in_sp.ip + {63'b0, in_sp.half};

  // The working value split into its integer term and the exact fraction.
  logic [10:0] x_e;
  split_t      x_sp;

  assign x_e  = x_r[62:52];
  assign x_sp = split({1'b1, x_r[51:0]}, x_e);

  // Checked a*h0+h1 or a*k0+k1; both addends are at most LMAX, so bit 63 of
  // the sum flags the overflow.
  logic [63:0] mac_sum;
  logic        mac_fail;

  assign mac_sum  = mul_prod[63:0] + ((state_r == S_MUL_K) ? k1_r : h1_r);
  assign mac_fail = (|mul_prod[127:63]) | mac_sum[63];

  // Alignment for |q - mag|. Shifted-out bits of the smaller operand are
  // folded in as a borrow plus sticky, which keeps the rounding exact.
  logic         q_ge;
  logic [63:0]  big, sml;
  logic [52:0]  mb, ms;
  logic [10:0]  dexp;
  logic [255:0] sh256;
  logic [127:0] ws;
  logic         lost;
  norm_req_t    sub_req;

  always_comb begin
    q_ge  = q_r >= mag_r;
    big   = q_ge ? q_r : mag_r;
    sml   = q_ge ? mag_r : q_r;
    mb    = {1'b1, big[51:0]};
    ms    = (sml == '0) ? 53'd0 : {1'b1, sml[51:0]};
    dexp  = big[62:52] - sml[62:52];
    sh256 = {ms, 203'b0} >> dexp[6:0];
    if (dexp > 11'd127) begin
      ws   = '0;
      lost = ms != '0;
    end else begin
      ws   = sh256[255:128];
      lost = |sh256[127:0];
    end
    sub_req.w      = {mb, 75'b0} - ws - {127'b0, lost};
    sub_req.ew     = exp_t'({3'b0, big[62:52]}) - NORM_BIAS;
    sub_req.sticky = lost;
  end

  exp_t div_ew;
  assign div_ew = exp_t'({3'b0, en_r}) - exp_t'({3'b0, ed_r}) - 14'sd56;

  // Finish conditions: one result per item, taken from whichever state ends it.
  logic        fin;
  status_t     fin_status;
  logic [63:0] fin_val;
  logic [63:0] fin_den;

  always_comb begin
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_val    = '0;
    fin_den    = 64'd1;
    unique case (state_r)
      S_CHECK: begin
        fin = 1'b1;
        priority if (in_e == EXP_INF) begin
          fin_status = ST_NONFINITE;
        end else if (in_e <= EXP_MAXINT && in_sp.fr == '0) begin
          fin_val = in_sp.ip;
        end else if (mag_r < LO_BITS || mag_r > TWO63_BITS) begin
          fin_status = ST_RANGE;
        end else if (mag_r == LO_BITS) begin
          fin_val = 64'd1;
          fin_den = LMAX;
        end else if (mag_r == TWO63_BITS) begin
          fin_val = LMAX;
        end else begin
          fin = 1'b0;
        end
      end
      S_LOOP: begin
        fin     = x_r >= TWO63_BITS;
        fin_val = hb_r;
        fin_den = kb_r;
      end
      S_MUL_H: begin
        fin     = mul_done & mac_fail;
        fin_val = hb_r;
        fin_den = kb_r;
      end
      S_MUL_K: begin
        fin     = mul_done & (mac_fail | (mac_sum == '0));
        fin_val = hb_r;
        fin_den = kb_r;
      end
      S_SUB_W: begin
        // An exact hit or a zero remainder both end on the new convergent.
        fin     = norm_done & !init_r & ((norm_res == '0) | (frac_r == '0));
        fin_val = hn_r;
        fin_den = kn_r;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      norm_go_r   <= 1'b0;
      init_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      norm_go_r   <= 1'b0;
      if (fin) begin
        out_valid_r  <= 1'b1;
        out_status_r <= fin_status;
        out_num_r    <= neg_r ? (~fin_val + 64'd1) : fin_val;
        out_den_r    <= fin_den[62:0];
        busy_r       <= 1'b0;
        state_r      <= S_IDLE;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            if (start) begin
              mag_r   <= {1'b0, in_value_bits[62:0]};
              neg_r   <= in_value_bits[63];
              busy_r  <= 1'b1;
              state_r <= S_CHECK;
            end
          end
          S_CHECK: begin
            // The start value is the magnitude rounded half away from zero.
            hb_r       <= hb_start;
            kb_r       <= 64'd1;
            h0_r       <= 64'd1;
            h1_r       <= 64'd0;
            k0_r       <= 64'd0;
            k1_r       <= 64'd1;
            x_r        <= mag_r;
            init_r     <= 1'b1;
            norm_go_r  <= 1'b1;
            norm_req_r <= '{w: {64'b0, hb_start}, ew: 14'sd0, sticky: 1'b0};
            state_r    <= S_HB_CVT;
          end
          S_HB_CVT: begin
            if (norm_done) begin
              q_r     <= norm_res;
              state_r <= S_SUB;
            end
          end
          S_LOOP: begin
            a_r      <= x_sp.ip;
            frac_r   <= x_sp.fr;
            frew_r   <= exp_t'({3'b0, x_e}) - exp_t'({3'b0, EXP_UNIT});
            mul_b_r  <= h0_r;
            mul_go_r <= 1'b1;
            state_r  <= S_MUL_H;
          end
          S_MUL_H: begin
            if (mul_done) begin
              hn_r     <= mac_sum;
              mul_b_r  <= k0_r;
              mul_go_r <= 1'b1;
              state_r  <= S_MUL_K;
            end
          end
          S_MUL_K: begin
            if (mul_done) begin
              kn_r       <= mac_sum;
              norm_go_r  <= 1'b1;
              norm_req_r <= '{w: {64'b0, hn_r}, ew: 14'sd0, sticky: 1'b0};
              state_r    <= S_CVT_H;
            end
          end
          S_CVT_H: begin
            if (norm_done) begin
              dh_r       <= norm_res;
              norm_go_r  <= 1'b1;
              norm_req_r <= '{w: {64'b0, kn_r}, ew: 14'sd0, sticky: 1'b0};
              state_r    <= S_CVT_K;
            end
          end
          S_CVT_K: begin
            if (norm_done) begin
              if (dh_r == '0) begin
                q_r     <= '0;
                state_r <= S_SUB;
              end else begin
                div_mn_r <= {1'b1, dh_r[51:0]};
                div_md_r <= {1'b1, norm_res[51:0]};
                en_r     <= dh_r[62:52];
                ed_r     <= norm_res[62:52];
                div_go_r <= 1'b1;
                state_r  <= S_DIV_Q;
              end
            end
          end
          S_DIV_Q: begin
            if (div_done) begin
              norm_go_r  <= 1'b1;
              norm_req_r <= '{w: {71'b0, div_q}, ew: div_ew, sticky: div_sticky};
              state_r    <= S_RND_Q;
            end
          end
          S_RND_Q: begin
            if (norm_done) begin
              q_r     <= norm_res;
              state_r <= S_SUB;
            end
          end
          S_SUB: begin
            norm_go_r  <= 1'b1;
            norm_req_r <= sub_req;
            state_r    <= S_SUB_W;
          end
          S_SUB_W: begin
            if (norm_done) begin
              if (init_r) begin
                min_err_r <= norm_res;
                init_r    <= 1'b0;
                state_r   <= S_LOOP;
              end else begin
                if (norm_res < min_err_r) begin
                  hb_r      <= hn_r;
                  kb_r      <= kn_r;
                  min_err_r <= norm_res;
                end
                h1_r       <= h0_r;
                h0_r       <= hn_r;
                k1_r       <= k0_r;
                k0_r       <= kn_r;
                norm_go_r  <= 1'b1;
                norm_req_r <= '{w: {75'b0, frac_r}, ew: frew_r, sticky: 1'b0};
                state_r    <= S_REM;
              end
            end
          end
          S_REM: begin
            if (norm_done) begin
              div_mn_r <= ONE_MANT;
              div_md_r <= {1'b1, norm_res[51:0]};
              en_r     <= EXP_ONE;
              ed_r     <= norm_res[62:52];
              div_go_r <= 1'b1;
              state_r  <= S_DIV_X;
            end
          end
          S_DIV_X: begin
            if (div_done) begin
              norm_go_r  <= 1'b1;
              norm_req_r <= '{w: {71'b0, div_q}, ew: div_ew, sticky: div_sticky};
              state_r    <= S_RND_X;
            end
          end
          S_RND_X: begin
            if (norm_done) begin
              x_r     <= norm_res;
              state_r <= S_LOOP;
            end
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_numerator   = out_num_r;
  assign out_denominator = out_den_r;

  // A result ends the item, so the block is free while it is shown.
  a_free_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy while a result is shown");

  // A taken beat keeps the block busy until its result.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid)) else $error("taken beat left no work");

  // Error results carry 0/1.
  a_error_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_numerator == 64'sd0 &&
    out_denominator == 63'd1)) else $error("error result not 0/1");

  // The denominator is never zero.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_denominator != 63'd0) else $error("zero denominator");

endmodule
